>>> hdl/rius_pkg.sv
`default_nettype none

package rius_pkg;

  // word format
  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int REG_W  = 31;
  localparam int MAG_W  = WORD_W + FRAC_W;

  // iteration counters of the serial units
  localparam int MUL_CNT_W = $clog2(WORD_W);
  localparam int DIV_CNT_W = $clog2(MAG_W);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd2;

  // sweep modes
  localparam logic MODE_DENSITY = 1'b0;
  localparam logic MODE_ENERGY  = 1'b1;

  // fixed point constants
  localparam logic [WORD_W-1:0] FX_ONE    = WORD_W'(64'd1 << FRAC_W);
  localparam logic [REG_W-1:0]  REG_ONE   = REG_W'(64'd1 << FRAC_W);
  localparam logic [WORD_W-1:0] WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  masked;
    word_t theta_cell;
    word_t eta_cell;
    word_t mu_cell;
    word_t old_value;
    word_t density_n;
    logic  last_cell;
  } in_item_t;

  typedef struct packed {
    word_t new_value;
    logic  ray_end;
    logic  saturated;
  } out_item_t;

  // request to a serial arithmetic unit
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } op_req_t;

  // answer of a serial arithmetic unit, done is a one-cycle pulse
  typedef struct packed {
    logic  done;
    logic  sat;
    word_t value;
  } op_res_t;

  // magnitude of a signed word, the most negative word maps to 2^(WORD_W-1)
  function automatic logic [WORD_W-1:0] fx_mag(input word_t x);
    logic [WORD_W-1:0] u;
    u = x;
    return x[WORD_W-1] ? (~u + 1'b1) : u;
  endfunction

  // sign and magnitude back to a word, clamped; result is {sat, value}
  function automatic logic [WORD_W:0] sat_mag(input logic neg, input logic [MAG_W-1:0] m);
    logic [MAG_W-1:0]  lim;
    logic              s;
    logic [WORD_W-1:0] v;
    s = 1'b0;
    if (neg && (m != '0)) begin
      lim = MAG_W'(WORD_MIN);
      if (m > lim) begin
        s = 1'b1;
        v = WORD_MIN;
      end else begin
        v = ~m[WORD_W-1:0] + 1'b1;
      end
    end else begin
      lim = MAG_W'(WORD_MAX);
      if (m > lim) begin
        s = 1'b1;
        v = WORD_MAX;
      end else begin
        v = m[WORD_W-1:0];
      end
    end
    return {s, v};
  endfunction

  // saturating add of two words; result is {sat, value}
  function automatic logic [WORD_W:0] sat_add(input word_t x, input word_t y);
    logic [WORD_W:0] s;
    s = {x[WORD_W-1], x} + {y[WORD_W-1], y};
    if (s[WORD_W] != s[WORD_W-1]) begin
      return {1'b1, (s[WORD_W] ? WORD_MIN : WORD_MAX)};
    end
    return {1'b0, s[WORD_W-1:0]};
  endfunction

endpackage

`default_nettype wire

>>> hdl/rius_mul.sv
`default_nettype none

module rius_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  rius_pkg::op_req_t req,
  output rius_pkg::op_res_t res
);
  import rius_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;

  logic [1:0]           phase_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0]    ma_r;
  logic [WORD_W-1:0]    hi_r;
  logic [WORD_W-1:0]    lo_r;
  logic                 neg_r;
  logic                 done_r;
  logic                 sat_r;
  word_t                value_r;

  logic [WORD_W:0]      sum;
  logic [2*WORD_W-1:0]  prod;
  logic [WORD_W:0]      fin;

  // one multiplier bit per cycle: add the multiplicand, shift right
  always_comb begin
    sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, ma_r} : '0);
    prod = {hi_r, lo_r};
    fin  = sat_mag(neg_r, prod[2*WORD_W-1:FRAC_W]);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (phase_r == PH_FIN);
      case (phase_r)
        PH_IDLE: begin
          if (req.start) begin
            phase_r <= PH_RUN;
          end
        end
        PH_RUN: begin
          if (cnt_r == '0) begin
            phase_r <= PH_FIN;
          end
        end
        PH_FIN: begin
          phase_r <= PH_IDLE;
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (phase_r == PH_IDLE && req.start) begin
      ma_r  <= fx_mag(req.a);
      lo_r  <= fx_mag(req.b);
      hi_r  <= '0;
      neg_r <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
      cnt_r <= MUL_CNT_W'(WORD_W - 1);
    end else if (phase_r == PH_RUN) begin
      hi_r  <= sum[WORD_W:1];
      lo_r  <= {sum[0], lo_r[WORD_W-1:1]};
      cnt_r <= cnt_r - 1'b1;
    end
    if (phase_r == PH_FIN) begin
      sat_r   <= fin[WORD_W];
      value_r <= fin[WORD_W-1:0];
    end
  end

  assign res.done  = done_r;
  assign res.sat   = sat_r;
  assign res.value = value_r;

endmodule

`default_nettype wire

>>> hdl/rius_div.sv
`default_nettype none

module rius_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rius_pkg::op_req_t req,
  output rius_pkg::op_res_t res
);
  import rius_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;

  logic [1:0]           phase_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0]    d_r;
  logic [WORD_W-1:0]    rem_r;
  logic [MAG_W-1:0]     nq_r;
  logic                 neg_r;
  logic                 zero_r;
  logic                 xneg_r;
  logic                 xnz_r;
  logic                 done_r;
  logic                 sat_r;
  word_t                value_r;

  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      diff;
  logic                 ge;
  logic [WORD_W:0]      fin;

  // restoring division, one quotient bit per cycle; numerator bits leave
  // the top of nq_r while quotient bits enter at the bottom
  always_comb begin
    trial = {rem_r, nq_r[MAG_W-1]};
    diff  = trial - {1'b0, d_r};
    ge    = (trial >= {1'b0, d_r});
    if (zero_r) begin
      fin = {1'b1, (xneg_r ? WORD_MIN : (xnz_r ? WORD_MAX : '0))};
    end else begin
      fin = sat_mag(neg_r, nq_r);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (phase_r == PH_FIN);
      case (phase_r)
        PH_IDLE: begin
          if (req.start) begin
            phase_r <= PH_RUN;
          end
        end
        PH_RUN: begin
          if (cnt_r == '0) begin
            phase_r <= PH_FIN;
          end
        end
        PH_FIN: begin
          phase_r <= PH_IDLE;
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (phase_r == PH_IDLE && req.start) begin
      d_r    <= fx_mag(req.b);
      nq_r   <= {fx_mag(req.a), {FRAC_W{1'b0}}};
      rem_r  <= '0;
      neg_r  <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
      zero_r <= (req.b == '0);
      xneg_r <= req.a[WORD_W-1];
      xnz_r  <= (req.a != '0);
      cnt_r  <= DIV_CNT_W'(MAG_W - 1);
    end else if (phase_r == PH_RUN) begin
      rem_r <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      nq_r  <= {nq_r[MAG_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
    if (phase_r == PH_FIN) begin
      sat_r   <= fin[WORD_W];
      value_r <= fin[WORD_W-1:0];
    end
  end

  assign res.done  = done_r;
  assign res.sat   = sat_r;
  assign res.value = value_r;

endmodule

`default_nettype wire

>>> hdl/radial_implicit_upwind_sweep.sv
`default_nettype none

// Implicit upwind sweep along one radial ray, signed Q16.16. Cells enter
// innermost first, one item per cell, and each gives one result item; the
// quotient of a cell feeds the next, so cells are worked one at a time by a
// sequencer driving a shared bit-serial multiplier and a bit-serial divider
// (48 quotient bits). A masked cell, or a first cell that gives zero, needs
// no arithmetic; a density-mode cell five products and one quotient; an
// energy-mode cell six and one quotient, or three products when its
// denominator is zero; an energy-mode first cell with positive mu only a
// quotient. A new item is taken while the previous result still waits in
// the output register. Write configuration through cfg_wr_en, cfg_index
// and cfg_wdata only while no cell is in flight; the block does not check.
module radial_implicit_upwind_sweep (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rius_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rius_pkg::out_item_t                  out_item,
  input  logic                                 cfg_wr_en,
  input  logic [rius_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rius_pkg::REG_W-1:0]           cfg_wdata
);
  import rius_pkg::*;

  // sequencer steps: idle, one per product or quotient, and output
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LT   = 4'd1;  // lambda * theta
  localparam logic [3:0] ST_NA   = 4'd2;  // n * (1 + lambda*theta)
  localparam logic [3:0] ST_DM   = 4'd3;  // dt * mu
  localparam logic [3:0] ST_LP   = 4'd4;  // lambda * prev_theta
  localparam logic [3:0] ST_LV   = 4'd5;  // tmp * prev_value
  localparam logic [3:0] ST_NB   = 4'd6;  // n * inner
  localparam logic [3:0] ST_DE   = 4'd7;  // dt * eta
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic             mode_r;
  logic [REG_W-1:0] dt_r;
  logic [REG_W-1:0] lam_r;
  word_t            prev_value_r;
  word_t            prev_theta_r;
  logic             at_start_r;
  logic [3:0]       state_r;
  logic             issue_r;
  logic             sat_r;
  logic             out_valid_r;

  in_item_t         item_r;
  word_t            acc_a_r;
  word_t            acc_b_r;
  word_t            tmp_r;
  word_t            result_r;
  out_item_t        out_r;

  op_req_t          mul_req;
  op_res_t          mul_res;
  op_req_t          div_req;
  op_res_t          div_res;

  word_t            dt_w;
  word_t            lam_w;
  word_t            add_x;
  logic [WORD_W:0]  add_res;
  logic             mul_state;
  logic             in_fire;
  logic             out_load;
  logic             first_div;

  rius_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .res   (mul_res)
  );

  rius_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign dt_w      = {1'b0, dt_r};
  assign lam_w     = {1'b0, lam_r};
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign first_div = !in_item.masked && (mode_r == MODE_ENERGY) &&
                     !in_item.mu_cell[WORD_W-1] && (in_item.mu_cell != '0);

  // operand selection for the shared multiplier
  always_comb begin
    mul_state = 1'b1;
    mul_req.a = lam_w;
    mul_req.b = item_r.theta_cell;
    case (state_r)
      ST_LT: begin
        mul_req.a = lam_w;
        mul_req.b = item_r.theta_cell;
      end
      ST_NA: begin
        mul_req.a = item_r.density_n;
        mul_req.b = acc_a_r;
      end
      ST_DM: begin
        mul_req.a = dt_w;
        mul_req.b = item_r.mu_cell;
      end
      ST_LP: begin
        mul_req.a = lam_w;
        mul_req.b = prev_theta_r;
      end
      ST_LV: begin
        mul_req.a = tmp_r;
        mul_req.b = prev_value_r;
      end
      ST_NB: begin
        mul_req.a = item_r.density_n;
        mul_req.b = acc_b_r;
      end
      ST_DE: begin
        mul_req.a = dt_w;
        mul_req.b = item_r.eta_cell;
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
    mul_req.start = mul_state && !issue_r;
  end

  // divider operands: eta/mu on the first cell of a ray, else b/a
  always_comb begin
    div_req.start = (state_r == ST_DIV) && !issue_r;
    div_req.a     = at_start_r ? item_r.eta_cell : acc_b_r;
    div_req.b     = at_start_r ? item_r.mu_cell  : acc_a_r;
  end

  // saturating add that follows a product
  always_comb begin
    case (state_r)
      ST_LT:   add_x = FX_ONE;
      ST_DM:   add_x = acc_a_r;
      ST_LV:   add_x = item_r.old_value;
      default: add_x = acc_b_r;
    endcase
    add_res = sat_add(add_x, mul_res.value);
  end

  // configuration, sequencer and ray state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_DENSITY;
      dt_r         <= REG_ONE;
      lam_r        <= REG_ONE;
      prev_value_r <= '0;
      prev_theta_r <= '0;
      at_start_r   <= 1'b1;
      state_r      <= ST_IDLE;
      issue_r      <= 1'b0;
      sat_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MODE:   mode_r <= cfg_wdata[0];
          CFG_DT:     dt_r   <= cfg_wdata;
          CFG_LAMBDA: lam_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      if (mul_req.start || div_req.start) begin
        issue_r <= 1'b1;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            sat_r <= 1'b0;
            if (in_item.masked) begin
              state_r <= ST_OUT;
            end else if (at_start_r) begin
              state_r <= first_div ? ST_DIV : ST_OUT;
            end else begin
              state_r <= ST_LT;
            end
          end
        end
        ST_LT: begin
          if (mul_res.done) begin
            issue_r <= 1'b0;
            sat_r   <= sat_r | mul_res.sat | add_res[WORD_W];
            state_r <= (mode_r == MODE_ENERGY) ? ST_NA : ST_DM;
          end
        end
        ST_NA: begin
          if (mul_res.done) begin
            issue_r <= 1'b0;
            sat_r   <= sat_r | mul_res.sat;
            state_r <= ST_DM;
          end
        end
        ST_DM: begin
          if (mul_res.done) begin
            issue_r <= 1'b0;
            sat_r   <= sat_r | mul_res.sat | add_res[WORD_W];
            if (mode_r == MODE_DENSITY) begin
              state_r <= ST_LP;
            end else if (add_res[WORD_W-1:0] == '0) begin
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_LV;
            end
          end
        end
        ST_LP: begin
          if (mul_res.done) begin
            issue_r <= 1'b0;
            sat_r   <= sat_r | mul_res.sat;
            state_r <= ST_LV;
          end
        end
        ST_LV: begin
          if (mul_res.done) begin
            issue_r <= 1'b0;
            sat_r   <= sat_r | mul_res.sat | add_res[WORD_W];
            state_r <= (mode_r == MODE_ENERGY) ? ST_NB : ST_DE;
          end
        end
        ST_NB: begin
          if (mul_res.done) begin
            issue_r <= 1'b0;
            sat_r   <= sat_r | mul_res.sat;
            state_r <= ST_DE;
          end
        end
        ST_DE: begin
          if (mul_res.done) begin
            issue_r <= 1'b0;
            sat_r   <= sat_r | mul_res.sat | add_res[WORD_W];
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            issue_r <= 1'b0;
            sat_r   <= sat_r | div_res.sat;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            prev_value_r <= result_r;
            prev_theta_r <= item_r.theta_cell;
            at_start_r   <= item_r.last_cell;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // cell operands, intermediate values and the output register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r   <= in_item;
      result_r <= '0;
    end
    if (mul_res.done) begin
      case (state_r)
        ST_LT: begin
          tmp_r   <= mul_res.value;
          acc_a_r <= add_res[WORD_W-1:0];
        end
        ST_NA: acc_a_r <= mul_res.value;
        ST_DM: begin
          acc_a_r <= add_res[WORD_W-1:0];
          if (add_res[WORD_W-1:0] == '0) begin
            result_r <= prev_value_r;
          end
        end
        ST_LP: tmp_r   <= mul_res.value;
        ST_LV: acc_b_r <= add_res[WORD_W-1:0];
        ST_NB: acc_b_r <= mul_res.value;
        ST_DE: acc_b_r <= add_res[WORD_W-1:0];
        default: ;
      endcase
    end
    if (div_res.done && state_r == ST_DIV) begin
      result_r <= div_res.value;
    end
    if (out_load) begin
      out_r.new_value <= result_r;
      out_r.ray_end   <= item_r.last_cell;
      out_r.saturated <= sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
  import rius_pkg::*;

  typedef logic signed [63:0] wide_t;

  localparam wide_t W_MAX = 64'sd2147483647;
  localparam wide_t W_MIN = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 300;
  localparam int SEGMENT_CELLS = 161;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_wdata = '0;

  // cells waiting to be sent and results waiting to arrive
  in_item_t  cell_q[$];
  out_item_t pending_results[$];

  logic in_acc = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  // configuration and ray state as the block should hold them
  logic             cur_mode   = MODE_DENSITY;
  logic [REG_W-1:0] cur_dt     = REG_ONE;
  logic [REG_W-1:0] cur_lambda = REG_ONE;
  wide_t            ray_prev_value = 0;
  wide_t            ray_prev_theta = 0;
  logic             ray_at_start   = 1'b1;
  logic             calc_sat;

  radial_implicit_upwind_sweep DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fixed point arithmetic, saturation noted in calc_sat
  function automatic wide_t sx(logic [31:0] v);
    return $signed({{32{v[31]}}, v});
  endfunction

  function automatic logic [63:0] abs_w(wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic wide_t clamp_mag(bit neg, logic [63:0] m);
    logic [63:0] lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) begin
      calc_sat = 1'b1;
      return neg ? W_MIN : W_MAX;
    end
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic wide_t q_add(wide_t x, wide_t y);
    wide_t s;
    s = x + y;
    if (s > W_MAX) begin
      calc_sat = 1'b1;
      return W_MAX;
    end
    if (s < W_MIN) begin
      calc_sat = 1'b1;
      return W_MIN;
    end
    return s;
  endfunction

  function automatic wide_t q_mul(wide_t x, wide_t y);
    logic [63:0] p;
    p = (abs_w(x) * abs_w(y)) >> FRAC_W;
    return clamp_mag(((x < 0) != (y < 0)) && (p != 0), p);
  endfunction

  function automatic wide_t q_div(wide_t x, wide_t y);
    logic [63:0] q;
    if (y == 0) begin
      calc_sat = 1'b1;
      return (x > 0) ? W_MAX : ((x < 0) ? W_MIN : 0);
    end
    q = (abs_w(x) << FRAC_W) / abs_w(y);
    return clamp_mag(((x < 0) != (y < 0)) && (q != 0), q);
  endfunction

  // expected result of one cell, advances the ray state
  function automatic out_item_t upwind_cell(in_item_t c);
    wide_t theta, eta, mu, old, n, dt, lam, one;
    wide_t res, a, b, lt, inner;
    logic flag;
    out_item_t r;
    calc_sat = 1'b0;
    theta = sx(c.theta_cell);
    eta   = sx(c.eta_cell);
    mu    = sx(c.mu_cell);
    old   = sx(c.old_value);
    n     = sx(c.density_n);
    dt    = $signed({33'd0, cur_dt});
    lam   = $signed({33'd0, cur_lambda});
    one   = sx(FX_ONE);
    res   = 0;
    flag  = 1'b0;
    if (c.masked) begin
      res = 0;
    end else if (ray_at_start) begin
      // first cell: energy mode with positive mu starts from eta/mu, else zero
      if (cur_mode == MODE_ENERGY && mu > 0) begin
        res  = q_div(eta, mu);
        flag = calc_sat;
      end
    end else if (cur_mode == MODE_DENSITY) begin
      a = q_add(q_add(one, q_mul(lam, theta)), q_mul(dt, mu));
      b = q_add(q_add(old, q_mul(q_mul(lam, ray_prev_theta), ray_prev_value)),
                q_mul(dt, eta));
      res  = q_div(b, a);
      flag = calc_sat;
    end else begin
      lt = q_mul(lam, theta);
      a  = q_add(q_mul(n, q_add(one, lt)), q_mul(dt, mu));
      // zero denominator keeps the previous cell's value
      if (a == 0) begin
        res = ray_prev_value;
      end else begin
        inner = q_add(old, q_mul(lt, ray_prev_value));
        b     = q_add(q_mul(n, inner), q_mul(dt, eta));
        res   = q_div(b, a);
      end
      flag = calc_sat;
    end
    ray_prev_value = res;
    ray_prev_theta = theta;
    ray_at_start   = c.last_cell;
    r.new_value = res[31:0];
    r.ray_end   = c.last_cell;
    r.saturated = flag;
    return r;
  endfunction

  // sender: next cell at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc) begin
        if (cell_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= cell_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: check results, predict accepted cells
  always @(posedge clk) begin
    out_item_t want;
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result item: new_value %0d, ray_end %0b, saturated %0b",
                 out_item.new_value, out_item.ray_end, out_item.saturated);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.new_value !== want.new_value) begin
            $error("new_value: expected %0d, got %0d", want.new_value, out_item.new_value);
            mismatches++;
          end
          if (out_item.ray_end !== want.ray_end) begin
            $error("ray_end: expected %0b, got %0b", want.ray_end, out_item.ray_end);
            mismatches++;
          end
          if (out_item.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, out_item.saturated);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(upwind_cell(in_item));
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic queue_cell(bit msk, logic [31:0] th, logic [31:0] et, logic [31:0] mu,
                            logic [31:0] old, logic [31:0] n, bit last);
    in_item_t c;
    c.masked     = msk;
    c.theta_cell = th;
    c.eta_cell   = et;
    c.mu_cell    = mu;
    c.old_value  = old;
    c.density_n  = n;
    c.last_cell  = last;
    cell_q.push_back(c);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MODE:   cur_mode   = val[0];
      CFG_DT:     cur_dt     = val;
      CFG_LAMBDA: cur_lambda = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // block idle: nothing queued, nothing offered, no result outstanding
  task automatic wait_drained();
    do @(posedge clk);
    while (cell_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return $urandom();
      1: return WORD_MAX;
      2: return WORD_MIN;
      3: return '0;
      4: return FX_ONE;
      default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_reg();
    case ($urandom_range(7))
      0: return '0;
      1: return {REG_W{1'b1}};
      2, 3: return REG_ONE;
      4: return REG_W'($urandom());
      default: return REG_W'($urandom_range(32'h0002_0000));
    endcase
  endfunction

  // one ray of random cells, now and then a stray ray end or zero denominator
  task automatic queue_ray(int len);
    logic [31:0] th, mu, n;
    bit last;
    for (int i = 0; i < len; i++) begin
      th   = rand_word();
      mu   = rand_word();
      n    = rand_word();
      last = (i == len - 1) || ($urandom_range(19) == 0);
      if ($urandom_range(11) == 0) begin
        if (cur_mode == MODE_ENERGY) begin
          n  = '0;
          mu = '0;
        end else begin
          th = '0;
          if (cur_dt == REG_ONE) mu = -FX_ONE;
        end
      end
      queue_cell($urandom_range(9) == 0, th, rand_word(), mu, rand_word(), n, last);
    end
  endtask

  task automatic run_segment(int n_cells);
    int queued;
    int len;
    wait_drained();
    write_reg(CFG_MODE, REG_W'($urandom_range(1)));
    write_reg(CFG_DT, rand_reg());
    write_reg(CFG_LAMBDA, rand_reg());
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, REG_W'($urandom()));
    queued = 0;
    while (queued < n_cells) begin
      len = $urandom_range(1, 12);
      if (len > n_cells - queued) len = n_cells - queued;
      queue_ray(len);
      queued += len;
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 53;

    // density mode at reset settings
    queue_cell(1'b0, FX_ONE, FX_ONE, FX_ONE, 32'h0002_0000, FX_ONE, 1'b0);
    queue_cell(1'b0, FX_ONE, FX_ONE, FX_ONE, 32'h0002_0000, '0, 1'b0);
    // zero denominator with nonzero numerator
    queue_cell(1'b0, '0, FX_ONE, -FX_ONE, 32'h0005_0000, '0, 1'b0);
    queue_cell(1'b1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
    queue_cell(1'b0, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, 1'b0);
    queue_cell(1'b0, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, 1'b1);
    queue_cell(1'b0, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, '0, 1'b0);
    // zero over zero
    queue_cell(1'b0, '0, '0, -FX_ONE, '0, '0, 1'b1);

    // energy mode, largest time step, no transport
    wait_drained();
    write_reg(CFG_MODE, REG_W'(MODE_ENERGY));
    write_reg(CFG_DT, {REG_W{1'b1}});
    write_reg(CFG_LAMBDA, '0);
    write_reg(CFG_UNUSED, REG_ONE);
    queue_cell(1'b1, '0, FX_ONE, FX_ONE, '0, FX_ONE, 1'b1);
    queue_cell(1'b0, '0, FX_ONE, -FX_ONE, '0, FX_ONE, 1'b1);
    queue_cell(1'b0, '0, FX_ONE, '0, '0, FX_ONE, 1'b1);
    queue_cell(1'b0, '0, WORD_MAX, 32'd1, '0, FX_ONE, 1'b1);
    queue_cell(1'b0, FX_ONE, 32'h0003_0000, 32'h0002_0000, '0, FX_ONE, 1'b0);
    // zero denominator keeps the previous value
    queue_cell(1'b0, FX_ONE, FX_ONE, '0, FX_ONE, '0, 1'b0);
    queue_cell(1'b0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
    queue_cell(1'b0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1);

    // energy mode, zero time step, largest lambda
    wait_drained();
    write_reg(CFG_DT, '0);
    write_reg(CFG_LAMBDA, {REG_W{1'b1}});
    queue_cell(1'b0, WORD_MAX, WORD_MIN, WORD_MAX, '0, '0, 1'b0);
    queue_cell(1'b0, FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE, 1'b0);
    queue_cell(1'b0, FX_ONE, FX_ONE, FX_ONE, FX_ONE, '0, 1'b1);

    // random rays under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 27; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 4; seg++) run_segment(SEGMENT_CELLS);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
